/* rtl/acrle_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ASCII-count run-length decoder.
// No dependencies; imported by every module of the block.
package acrle_pkg;

  localparam int unsigned CNT_W     = 12;
  localparam int unsigned FIELD_MAX = 4095;

  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_STRAY = 2'd1;
  localparam logic [1:0] ERR_SAT   = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE     = 4'b0001,
    M_LIT_CNT  = 4'b0010,
    M_LIT_PASS = 4'b0100,
    M_RUN_CNT  = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   left;
    logic               ovf;
  } parse_st_t;

  typedef struct packed {
    logic               vld;
    logic [7:0]         data;
    logic [CNT_W-1:0]   rep;
    logic [1:0]         err;
  } parse_res_t;

endpackage

/* rtl/acrle_count.sv */
`timescale 1ns / 1ps
// Decimal count accumulator: count * 10 + digit with saturation at the cap.
// Depends on acrle_pkg.
module acrle_count import acrle_pkg::*; #(
  parameter int unsigned COUNT_CAP = 4095
) (
  input  logic [CNT_W-1:0] acc_i,
  input  logic             ovf_i,
  input  logic [3:0]       digit,
  output logic [CNT_W-1:0] acc_o,
  output logic             ovf_o
);

  localparam int unsigned SUM_W = CNT_W + 4;
  localparam logic [SUM_W-1:0] CAP = SUM_W'(COUNT_CAP);

  logic [SUM_W-1:0] sum;

  // times ten as shift-add
  assign sum = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} + {{(SUM_W-4){1'b0}}, digit};

  always_comb begin
    if (sum > CAP) begin
      acc_o = CAP[CNT_W-1:0];
      ovf_o = 1'b1;
    end else begin
      acc_o = sum[CNT_W-1:0];
      ovf_o = ovf_i;
    end
  end

endmodule

/* rtl/acrle_parse.sv */
`timescale 1ns / 1ps
// Parser step: next parse state and the optional result for one byte.
// Depends on acrle_pkg and acrle_count.
module acrle_parse import acrle_pkg::*; #(
  parameter int unsigned COUNT_CAP = 4095
) (
  input  parse_st_t  st,
  input  logic [7:0] data,
  output parse_st_t  st_nxt,
  output parse_res_t res
);

  logic             dig;
  logic             do_idle;
  logic [CNT_W-1:0] acc_add;
  logic             ovf_add;
  logic [CNT_W-1:0] lit_left;
  logic [CNT_W-1:0] pass_left;
  logic [3:0]       digit_val;

  assign digit_val = 4'(data - CHR_ZERO);
  assign lit_left  = st.count - CNT_W'(1);
  assign pass_left = st.left - CNT_W'(1);

  // count is always zero in idle, so the same adder serves the first digit
  acrle_count #(.COUNT_CAP(COUNT_CAP)) u_count (
    .acc_i (st.count),
    .ovf_i (st.ovf),
    .digit (digit_val),
    .acc_o (acc_add),
    .ovf_o (ovf_add)
  );

  always_comb begin
    dig      = data inside {[CHR_ZERO:CHR_NINE]};
    do_idle  = 1'b0;
    st_nxt   = st;
    res.vld  = 1'b0;
    res.data = data;
    res.rep  = '0;
    res.err  = ERR_NONE;

    case (st.mode)
      M_LIT_CNT: begin
        if (dig) begin
          st_nxt.count = acc_add;
          st_nxt.ovf   = ovf_add;
        end else if (st.count == '0) begin
          do_idle = 1'b1;
        end else begin
          res.vld      = 1'b1;
          res.rep      = CNT_W'(1);
          res.err      = st.ovf ? ERR_SAT : ERR_NONE;
          st_nxt.left  = lit_left;
          st_nxt.count = '0;
          st_nxt.ovf   = 1'b0;
          st_nxt.mode  = (lit_left != '0) ? M_LIT_PASS : M_IDLE;
        end
      end
      M_LIT_PASS: begin
        res.vld     = 1'b1;
        res.rep     = CNT_W'(1);
        st_nxt.left = pass_left;
        if (pass_left == '0) begin
          st_nxt.mode = M_IDLE;
        end
      end
      M_RUN_CNT: begin
        if (dig) begin
          st_nxt.count = acc_add;
          st_nxt.ovf   = ovf_add;
        end else begin
          // zero count: consume the run byte, emit nothing
          res.vld      = st.count != '0;
          res.rep      = st.count;
          res.err      = st.ovf ? ERR_SAT : ERR_NONE;
          st_nxt.mode  = M_IDLE;
          st_nxt.count = '0;
          st_nxt.ovf   = 1'b0;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      st_nxt.count = '0;
      st_nxt.ovf   = 1'b0;
      if (data == CHR_MINUS) begin
        st_nxt.mode = M_LIT_CNT;
      end else if (dig) begin
        st_nxt.mode  = M_RUN_CNT;
        st_nxt.count = acc_add;
        st_nxt.ovf   = ovf_add;
      end else begin
        // drop the stray byte and flag it
        st_nxt.mode = M_IDLE;
        res.vld     = 1'b1;
        res.rep     = '0;
        res.err     = ERR_STRAY;
      end
    end
  end

endmodule

/* rtl/ascii_count_rle_decoder.sv */
`timescale 1ns / 1ps
// Top level of the ASCII-count run-length decoder: input register, parser
// state, result register. Depends on acrle_pkg, acrle_parse, acrle_count.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_byte             | request in
//  result  | out_valid, out_stall, out_byte,         | request out
//          | out_repeat_count, out_error_code        |
//
// One byte per cycle unless stalled: a byte is registered, parsed in one step
// against the parse state, and its result is registered in the output register.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
// A stall on the result side holds the output register and the staged byte;
// in_stall rises only while a staged byte cannot move on.
module ascii_count_rle_decoder import acrle_pkg::*; #(
  parameter int unsigned MAX_COUNT = 4095
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [CNT_W-1:0] out_repeat_count,
  output logic [1:0]       out_error_code
);

  localparam int unsigned COUNT_CAP = (MAX_COUNT > FIELD_MAX) ? FIELD_MAX : MAX_COUNT;

  logic             s1_vld_r;
  logic [7:0]       s1_byte_r;
  logic             s1_adv;
  parse_st_t        st_r;
  parse_st_t        st_nxt;
  parse_res_t       res;
  logic             out_vld_r;
  logic [7:0]       out_byte_r;
  logic [CNT_W-1:0] out_rep_r;
  logic [1:0]       out_err_r;

  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;

  acrle_parse #(.COUNT_CAP(COUNT_CAP)) u_parse (
    .st     (st_r),
    .data   (s1_byte_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode  <= M_IDLE;
      st_r.count <= '0;
      st_r.left  <= '0;
      st_r.ovf   <= 1'b0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= res.vld;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.vld) begin
      out_byte_r <= res.data;
      out_rep_r  <= res.rep;
      out_err_r  <= res.err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte         = out_byte_r;
  assign out_repeat_count = out_rep_r;
  assign out_error_code   = out_err_r;

  a_pass_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == M_LIT_PASS |-> st_r.left != '0)
    else $error("literal pass with no bytes left");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == M_IDLE |-> (st_r.count == '0 && !st_r.ovf))
    else $error("count not cleared in idle");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count <= CNT_W'(COUNT_CAP))
    else $error("count above cap");

  a_stray_zero_rep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_err_r == ERR_STRAY) |-> out_rep_r == '0)
    else $error("stray byte with nonzero repeat count");

  a_good_nonzero_rep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_err_r == ERR_NONE || out_err_r == ERR_SAT)) |-> out_rep_r != '0)
    else $error("decoded item with zero repeat count");

endmodule

/* tb/ascii_count_rle_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ascii_count_rle_decoder: feeds encoded byte streams,
// predicts every decoded run and compares each result request as it leaves.
// Depends on acrle_pkg and the decoder RTL.
module ascii_count_rle_decoder_tb;
  import acrle_pkg::*;

  localparam int unsigned MAX_COUNT = 4095;
  localparam int unsigned COUNT_CAP = (MAX_COUNT > FIELD_MAX) ? FIELD_MAX : MAX_COUNT;
  localparam int unsigned MAX_GAP   = 11;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned LONG_RUN  = 120;

  typedef struct packed {
    logic [7:0]       data;
    logic [CNT_W-1:0] rep;
    logic [1:0]       err;
  } decoded_run_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic [CNT_W-1:0] out_repeat_count;
  logic [1:0]       out_error_code;

  // predicted parser state
  mode_t            exp_mode = M_IDLE;
  logic [CNT_W-1:0] exp_count = '0;
  logic [CNT_W-1:0] exp_left = '0;
  logic             exp_sat = 1'b0;
  decoded_run_t     decoded_runs_due[$];

  int unsigned bytes_sent = 0;
  int unsigned runs_checked = 0;
  int unsigned mismatches = 0;
  int unsigned sat_runs = 0;
  int unsigned stray_runs = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          bus_busy = 1'b0;
  logic        long_hold = 1'b0;
  int unsigned rx_wait = 0;

  ascii_count_rle_decoder #(.MAX_COUNT(MAX_COUNT)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_repeat_count (out_repeat_count),
    .out_error_code   (out_error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit is_digit(logic [7:0] b);
    return b >= CHR_ZERO && b <= CHR_NINE;
  endfunction

  function automatic void emit_run(logic [7:0] b, logic [CNT_W-1:0] rep, logic [1:0] err);
    decoded_run_t r;
    r.data = b;
    r.rep  = rep;
    r.err  = err;
    decoded_runs_due.push_back(r);
    if (err == ERR_SAT) sat_runs++;
    if (err == ERR_STRAY) stray_runs++;
  endfunction

  function automatic void accum_digit(logic [7:0] b);
    int unsigned v;
    v = exp_count * 10 + (b - CHR_ZERO);
    if (v > COUNT_CAP) begin
      v = COUNT_CAP;
      exp_sat = 1'b1;
    end
    exp_count = v[CNT_W-1:0];
  endfunction

  function automatic void idle_decode(logic [7:0] b);
    exp_count = '0;
    exp_sat   = 1'b0;
    if (b == CHR_MINUS) begin
      exp_mode = M_LIT_CNT;
    end else if (is_digit(b)) begin
      exp_mode = M_RUN_CNT;
      accum_digit(b);
    end else begin
      exp_mode = M_IDLE;
      emit_run(b, '0, ERR_STRAY);
    end
  endfunction

  function automatic void predict_decode(logic [7:0] b);
    case (exp_mode)
      M_LIT_CNT: begin
        if (is_digit(b)) begin
          accum_digit(b);
        end else if (exp_count == 0) begin
          // empty literal count: the terminator is an ordinary idle byte
          idle_decode(b);
        end else begin
          emit_run(b, CNT_W'(1), exp_sat ? ERR_SAT : ERR_NONE);
          exp_left  = exp_count - CNT_W'(1);
          exp_count = '0;
          exp_sat   = 1'b0;
          exp_mode  = (exp_left != 0) ? M_LIT_PASS : M_IDLE;
        end
      end
      M_LIT_PASS: begin
        emit_run(b, CNT_W'(1), ERR_NONE);
        exp_left = exp_left - CNT_W'(1);
        if (exp_left == 0) exp_mode = M_IDLE;
      end
      M_RUN_CNT: begin
        if (is_digit(b)) begin
          accum_digit(b);
        end else begin
          exp_mode = M_IDLE;
          if (exp_count != 0) emit_run(b, exp_count, exp_sat ? ERR_SAT : ERR_NONE);
          exp_count = '0;
          exp_sat   = 1'b0;
        end
      end
      default: idle_decode(b);
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v)
      log_mismatch($sformatf("result %0d %s: expected %0h, got %0h",
                             runs_checked, name, want_v, got_v));
  endtask

  // Check each result request and draw the stall that follows it.
  always @(posedge clk) begin
    decoded_run_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        runs_checked++;
        if (decoded_runs_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result: byte %0h count %0d code %0d",
                                 out_byte, out_repeat_count, out_error_code));
        end else begin
          want = decoded_runs_due.pop_front();
          check_field("out_byte", 16'(want.data), 16'(out_byte));
          check_field("out_repeat_count", 16'(want.rep), 16'(out_repeat_count));
          check_field("out_error_code", 16'(want.err), 16'(out_error_code));
        end
        rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= long_hold || (rx_wait > 0);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0 && bus_busy) begin
      in_valid <= 1'b0;
      bus_busy = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    bus_busy = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_decode(b);
    bytes_sent++;
  endtask

  task automatic idle_bus();
    if (bus_busy) in_valid <= 1'b0;
    bus_busy = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_count(input int unsigned n, input int unsigned zeros);
    repeat (zeros) send_byte(CHR_ZERO);
    send_text($sformatf("%0d", n));
  endtask

  task automatic wait_drained();
    int unsigned spins;
    spins = 0;
    idle_bus();
    while (decoded_runs_due.size() != 0 && spins < 50000) begin
      @(posedge clk);
      spins++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic test_stray_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();
  endtask

  task automatic test_repeat_runs();
    send_text("3-");
    send_text("0Q");
    wait_drained();
  endtask

  task automatic test_literal_runs();
    send_text("-4");
    send_byte(8'h80);
    send_byte(CHR_MINUS);
    // pause mid-run until the first two literals are out
    wait_drained();
    send_byte(8'h7F);
    send_byte(CHR_NINE);
    wait_drained();
  endtask

  task automatic test_empty_counts();
    send_text("-0X");
    send_text("--1a");
    wait_drained();
  endtask

  task automatic test_saturated_counts();
    send_text("4095C");
    send_text("4096B");
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    fork
      begin
        long_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold <= 1'b0;
      end
      begin
        send_byte(CHR_MINUS);
        send_count(40, 0);
        repeat (40) send_byte(8'($urandom));
        idle_bus();
      end
    join
    tx_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_long_literal_run();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_byte(CHR_MINUS);
    send_count(LONG_RUN, 0);
    repeat (LONG_RUN) send_byte(8'($urandom));
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    start = bytes_sent;
    while (bytes_sent - start < 600) begin
      if ($urandom_range(0, 99) < 3) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 9) == 0) n = 0;
        else if ($urandom_range(0, 19) == 0) n = $urandom_range(3000, 99999);
        else n = $urandom_range(1, 40);
        send_count(n, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
        do b = 8'($urandom); while (is_digit(b));
        send_byte(b);
      end else if (pick < 75) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        send_byte(CHR_MINUS);
        send_count(n, 0);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 85) begin
        // sign with no count; a digit that follows becomes its count, anything else is parsed as in idle
        send_byte(CHR_MINUS);
      end else if (pick < 97) begin
        send_byte(8'($urandom));
      end else begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_bytes();
    test_repeat_runs();
    test_literal_runs();
    test_empty_counts();
    test_saturated_counts();
    test_backpressure();
    test_long_literal_run();
    test_random_stream();
    repeat (8) @(posedge clk);
    if (decoded_runs_due.size() != 0) begin
      $display("%0d decoded runs never arrived", decoded_runs_due.size());
      mismatches += decoded_runs_due.size();
    end
    $display("Decoded %0d stream bytes into %0d results (%0d saturated, %0d stray drops),",
             bytes_sent, runs_checked, sat_runs, stray_runs);
    $display("with a long output hold, a long back-to-back literal run and random idling.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* ascii_count_rle_decoder.f */
rtl/acrle_pkg.sv
rtl/acrle_count.sv
rtl/acrle_parse.sv
rtl/ascii_count_rle_decoder.sv
tb/ascii_count_rle_decoder_tb.sv
